// ===== rtl/ifsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifsp_pkg: shared types and constants of the ILDA frame stream parser
// Holds the parse phase, the command format that the front end queues for
// the back end, and the result and error codes.
// ----------------------------------------------------------------------------
package ifsp_pkg;

    localparam logic [31:0] ILDA_MAGIC = 32'h41444C49;
    localparam int unsigned BLANK_BIT  = 6;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [4:0] HDR_LAST_POS   = 5'd31;
    localparam logic [4:0] HDR_FORMAT_POS = 5'd7;
    localparam logic [2:0] COORD_BYTES_3D = 3'd6;
    localparam logic [2:0] COORD_BYTES_2D = 3'd4;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_POINTS = 2'd1,
        PH_ERROR  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_POINT  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_BAD_MAGIC = 2'd0,
        ERR_FORMAT    = 2'd1,
        ERR_TRUNCATED = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        OP_COORD  = 3'd0,
        OP_STATUS = 3'd1,
        OP_POINT  = 3'd2,
        OP_HEADER = 3'd3,
        OP_ERROR  = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic        is_3d;
        logic        last;
        t_err        err;
        logic [15:0] count;
        logic [15:0] frame;
    } t_cmd;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        magic_byte = ILDA_MAGIC[{pos, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/ifsp_front.sv =====
// ----------------------------------------------------------------------------
// ifsp_front: byte classifier of the ILDA frame stream parser
// Tracks header and point framing, checks magic and format, and turns each
// byte that matters into a command for the back end.
// ----------------------------------------------------------------------------
module ifsp_front import ifsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_end,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic        r_is_3d, n_is_3d;
    logic [15:0] r_remaining, n_remaining;
    logic        r_mismatch, n_mismatch;
    logic [7:0]  r_format, n_format;
    logic [31:0] r_hdr, n_hdr;

    logic       accept;
    logic [2:0] coord_bytes;

    assign accept      = i_valid && !i_full;
    assign coord_bytes = r_is_3d ? COORD_BYTES_3D : COORD_BYTES_2D;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_is_3d     <= 1'b0;
            r_remaining <= '0;
            r_mismatch  <= 1'b0;
            r_format    <= '0;
            r_hdr       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_is_3d     <= n_is_3d;
            r_remaining <= n_remaining;
            r_mismatch  <= n_mismatch;
            r_format    <= n_format;
            r_hdr       <= n_hdr;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_is_3d     = r_is_3d;
        n_remaining = r_remaining;
        n_mismatch  = r_mismatch;
        n_format    = r_format;
        n_hdr       = r_hdr;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.data  = i_data_byte;
        o_cmd.is_3d = r_is_3d;

        if (accept) begin
            if (i_stream_end) begin
                // A stream that stops inside a header or a frame is truncated.
                if (r_phase == PH_POINTS || (r_phase == PH_HEADER && r_pos != 5'd0)) begin
                    o_push    = 1'b1;
                    o_cmd.op  = OP_ERROR;
                    o_cmd.err = ERR_TRUNCATED;
                end
                n_phase    = PH_HEADER;
                n_pos      = '0;
                n_mismatch = 1'b0;
                n_hdr      = '0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_pos < 5'd4 && i_data_byte != magic_byte(r_pos[1:0])) begin
                            n_mismatch = 1'b1;
                        end
                        if (r_pos == HDR_FORMAT_POS) begin
                            n_format = i_data_byte;
                        end
                        if (r_pos inside {[5'd24:5'd27]}) begin
                            n_hdr = {r_hdr[23:0], i_data_byte};
                        end
                        if (r_pos != HDR_LAST_POS) begin
                            n_pos = r_pos + 5'd1;
                        end else begin
                            n_pos  = '0;
                            o_push = 1'b1;
                            if (r_mismatch) begin
                                o_cmd.op  = OP_ERROR;
                                o_cmd.err = ERR_BAD_MAGIC;
                                n_phase   = PH_ERROR;
                            end else if (r_format > 8'd1) begin
                                o_cmd.op  = OP_ERROR;
                                o_cmd.err = ERR_FORMAT;
                                n_phase   = PH_ERROR;
                            end else begin
                                o_cmd.op    = OP_HEADER;
                                o_cmd.count = r_hdr[31:16];
                                o_cmd.frame = r_hdr[15:0];
                                n_is_3d     = (r_format == 8'd0);
                                n_remaining = r_hdr[31:16];
                                n_hdr       = '0;
                                n_phase     = (r_hdr[31:16] != 16'd0) ? PH_POINTS : PH_HEADER;
                            end
                        end
                    end
                    PH_POINTS: begin
                        o_push = 1'b1;
                        if (r_pos[2:0] < coord_bytes) begin
                            o_cmd.op = OP_COORD;
                            n_pos    = r_pos + 5'd1;
                        end else if (r_pos[2:0] == coord_bytes) begin
                            o_cmd.op = OP_STATUS;
                            n_pos    = r_pos + 5'd1;
                        end else begin
                            o_cmd.op    = OP_POINT;
                            o_cmd.last  = (r_remaining == 16'd1);
                            n_pos       = '0;
                            n_remaining = r_remaining - 16'd1;
                            if (r_remaining == 16'd1) begin
                                n_phase = PH_HEADER;
                            end
                        end
                    end
                    PH_ERROR: begin
                        // Data bytes are dropped until the stream ends.
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/ifsp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ifsp_cmd_queue: command queue between front end and back end
// A short first-in first-out buffer of commands with a registered full flag.
// ----------------------------------------------------------------------------
module ifsp_cmd_queue import ifsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_cmd o_head
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_push, do_pop;

    assign o_full     = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/ifsp_back.sv =====
// ----------------------------------------------------------------------------
// ifsp_back: result builder of the ILDA frame stream parser
// Assembles point coordinates and status from queued commands and holds
// each result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module ifsp_back import ifsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  t_cmd               i_head,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic        [1:0]  o_kind,
    output logic signed [15:0] o_point_x,
    output logic signed [15:0] o_point_y,
    output logic signed [15:0] o_point_z,
    output logic        [7:0]  o_point_color,
    output logic               o_last_point,
    output logic        [15:0] o_frame_number,
    output logic        [15:0] o_point_count,
    output logic        [1:0]  o_error_code
);

    logic [47:0] r_asm;
    logic [7:0]  r_status;
    logic        r_valid;
    logic        out_free, emits, load;

    assign out_free = !r_valid || !i_stall;
    assign emits    = (i_head.op == OP_POINT) || (i_head.op == OP_HEADER) ||
                      (i_head.op == OP_ERROR);
    assign o_pop    = i_nonempty && (!emits || out_free);
    assign load     = o_pop && emits;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm    <= '0;
            r_status <= '0;
        end else if (o_pop) begin
            case (i_head.op)
                OP_COORD:  r_asm    <= {r_asm[39:0], i_head.data};
                OP_STATUS: r_status <= i_head.data;
                default:   r_asm    <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_point_x      <= '0;
            o_point_y      <= '0;
            o_point_z      <= '0;
            o_point_color  <= '0;
            o_last_point   <= 1'b0;
            o_frame_number <= '0;
            o_point_count  <= '0;
            o_error_code   <= '0;
            case (i_head.op)
                OP_POINT: begin
                    o_kind        <= KIND_POINT;
                    o_point_color <= r_status[BLANK_BIT] ? 8'd0 : i_head.data;
                    o_last_point  <= i_head.last;
                    if (i_head.is_3d) begin
                        o_point_x <= r_asm[47:32];
                        o_point_y <= r_asm[31:16];
                        o_point_z <= r_asm[15:0];
                    end else begin
                        o_point_x <= r_asm[31:16];
                        o_point_y <= r_asm[15:0];
                    end
                end
                OP_HEADER: begin
                    o_kind         <= KIND_HEADER;
                    o_frame_number <= i_head.frame;
                    o_point_count  <= i_head.count;
                end
                default: begin
                    o_kind       <= KIND_ERROR;
                    o_error_code <= i_head.err;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ilda_frame_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ilda_frame_stream_parser: ILDA laser frame stream parser
// Parses a byte stream of ILDA frames into header, point and error results.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one beat per file byte (i_data_byte) or an
// end-of-stream marker (i_stream_end). A beat is taken at a rising edge where
// i_valid is high and o_stall is low. The output channel presents one result
// beat on o_valid with its fields; the receiver holds it with i_stall.
// Throughput is one input beat per cycle while o_stall is low. A result is
// built in two steps: the front end writes a command into a four-entry queue
// at the edge that took the byte which completes it, and the back end moves
// it from the queue into the output register once that register is free.
// When the receiver stalls, the output register holds its beat, the back end
// keeps absorbing coordinate and status commands, and result commands wait
// in the queue; o_stall rises only once the queue is full, which is set by
// the queue depth and not by the parsing work.
// Reset (i_rst_n low at a clock edge) empties the queue, drops any pending
// result and restarts parsing at a frame header.
// ----------------------------------------------------------------------------
module ilda_frame_stream_parser import ifsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [7:0]  i_data_byte,
    input  logic               i_stream_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [1:0]  o_kind,
    output logic signed [15:0] o_point_x,
    output logic signed [15:0] o_point_y,
    output logic signed [15:0] o_point_z,
    output logic        [7:0]  o_point_color,
    output logic               o_last_point,
    output logic        [15:0] o_frame_number,
    output logic        [15:0] o_point_count,
    output logic        [1:0]  o_error_code
);

    // Command path from the classifier to the result builder.
    logic q_full, q_nonempty, q_push, q_pop;
    t_cmd push_cmd, head_cmd;

    // The input side stalls only on a full queue, so o_stall is registered.
    assign o_stall = q_full;

    ifsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    ifsp_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (push_cmd),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_cmd)
    );

    ifsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nonempty     (q_nonempty),
        .i_head         (head_cmd),
        .o_pop          (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_z      (o_point_z),
        .o_point_color  (o_point_color),
        .o_last_point   (o_last_point),
        .o_frame_number (o_frame_number),
        .o_point_count  (o_point_count),
        .o_error_code   (o_error_code)
    );

endmodule
